// File: src/umpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umpf_pkg: shared types and constants for the USB-MIDI packet filter
// Register indexes, channel mode codes and the byte constants used by the
// filter rules.
// ----------------------------------------------------------------------------
package umpf_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MODE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NOTES_ONLY         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CABLE_ZERO_ONLY    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DROP_CABLE_FIFTEEN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DROP_UI_CONTROLS   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_UI_CC_MASK_LOW     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_UI_CC_MASK_HIGH    = 3'd6;

  // Channel filtering modes
  typedef enum logic [1:0] {
    CHM_NONE      = 2'd0,
    CHM_CH3_ONLY  = 2'd1,
    CHM_BLOCK_CH1 = 2'd2,
    CHM_CH5_TO_8  = 2'd3
  } channel_mode_t;

  // Code index range that carries MIDI channel voice traffic
  localparam logic [3:0] CIN_MIN = 4'h8;
  localparam logic [3:0] CIN_MAX = 4'hE;

  // Cable numbers
  localparam logic [3:0] CABLE_ZERO    = 4'h0;
  localparam logic [3:0] CABLE_FIFTEEN = 4'hF;

  // Status kinds (high nibble)
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CC       = 4'hB;
  localparam logic [3:0] KIND_SYSTEM   = 4'hF;

  // Channel nibbles
  localparam logic [3:0] CHAN_ONE       = 4'h0;
  localparam logic [3:0] CHAN_THREE     = 4'h2;
  localparam logic [3:0] CHAN_FIVE      = 4'h4;
  localparam logic [3:0] CHAN_EIGHT     = 4'h7;

  // Notes below this number on cable zero are UI traffic
  localparam logic [7:0] UI_NOTE_LIMIT = 8'd10;

endpackage : umpf_pkg

// File: src/usb_midi_packet_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_midi_packet_filter: rule-based USB-MIDI packet filter
// Passes or zeroes each 4-byte packet, tracks whether a buffer carried any
// surviving packet and counts committed buffers.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | header, status, data_one, data_two, last
//  out     | out_valid/out_stall| passed, bytes, end_of_buffer, commit, count
//  cfg     | cfg_we             | cfg_index, cfg_data (write only)
//
//  One packet per cycle sustained while out_stall stays low; a packet passes
//  the input register, then the result register holding the filter verdict.
//  The buffer state (any-passed flag, committed count) updates as a packet
//  moves into the result register.
//  Synchronous active-low reset clears valids, config registers and buffer state.
//  out_stall holds the result register; in_stall rises only when both
//  stages are full and the result is stalled.
// ----------------------------------------------------------------------------
module usb_midi_packet_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_header,
  input  logic [7:0]                       in_status,
  input  logic [7:0]                       in_data_one,
  input  logic [7:0]                       in_data_two,
  input  logic                             in_last_in_buffer,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_passed,
  output logic [7:0]                       out_header,
  output logic [7:0]                       out_status,
  output logic [7:0]                       out_data_one,
  output logic [7:0]                       out_data_two,
  output logic                             out_end_of_buffer,
  output logic                             out_commit,
  output logic [7:0]                       out_ready_count,
  // Configuration
  input  logic                             cfg_we,
  input  logic [umpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [umpf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import umpf_pkg::*;

  // Configuration registers
  channel_mode_t channel_mode_r;
  logic          notes_only_r;
  logic          cable_zero_only_r;
  logic          drop_cable_fifteen_r;
  logic          drop_ui_controls_r;
  logic [63:0]   ui_cc_mask_low_r;
  logic [63:0]   ui_cc_mask_high_r;

  // Input stage
  logic       s1_valid_r;
  logic [7:0] s1_header_r;
  logic [7:0] s1_status_r;
  logic [7:0] s1_data_one_r;
  logic [7:0] s1_data_two_r;
  logic       s1_last_r;

  // Result stage and buffer state
  logic       out_valid_r;
  logic       out_passed_r;
  logic [7:0] out_header_r;
  logic [7:0] out_status_r;
  logic [7:0] out_data_one_r;
  logic [7:0] out_data_two_r;
  logic       out_eob_r;
  logic       out_commit_r;
  logic [7:0] ready_count_r;
  logic       any_passed_r;

  // Flow control
  logic s2_ready;
  logic s1_ready;
  logic s1_load;
  logic s2_load;

  // Filter datapath
  logic [3:0]   cin;
  logic [3:0]   cable;
  logic [3:0]   kind;
  logic [3:0]   chan;
  logic         is_note;
  logic         cc_masked;
  logic         drop_cin;
  logic         drop_cable;
  logic         drop_ui;
  logic         drop_notes;
  logic         drop_chan;
  logic         ok;
  logic         commit_nxt;
  logic         any_passed_nxt;
  logic [7:0]   ready_count_nxt;

  // Advance when the next stage is empty or draining
  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s1_load  = in_valid && s1_ready;
  assign s2_load  = s1_valid_r && s2_ready;
  assign in_stall = !s1_ready;

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_mode_r       <= CHM_NONE;
      notes_only_r         <= 1'b0;
      cable_zero_only_r    <= 1'b0;
      drop_cable_fifteen_r <= 1'b0;
      drop_ui_controls_r   <= 1'b0;
      ui_cc_mask_low_r     <= '0;
      ui_cc_mask_high_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_MODE:       channel_mode_r       <= channel_mode_t'(cfg_data[1:0]);
        REG_NOTES_ONLY:         notes_only_r         <= cfg_data[0];
        REG_CABLE_ZERO_ONLY:    cable_zero_only_r    <= cfg_data[0];
        REG_DROP_CABLE_FIFTEEN: drop_cable_fifteen_r <= cfg_data[0];
        REG_DROP_UI_CONTROLS:   drop_ui_controls_r   <= cfg_data[0];
        REG_UI_CC_MASK_LOW:     ui_cc_mask_low_r     <= cfg_data;
        REG_UI_CC_MASK_HIGH:    ui_cc_mask_high_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_header_r   <= in_header;
      s1_status_r   <= in_status;
      s1_data_one_r <= in_data_one;
      s1_data_two_r <= in_data_two;
      s1_last_r     <= in_last_in_buffer;
    end
  end

  // Split the packet fields
  assign cin     = s1_header_r[3:0];
  assign cable   = s1_header_r[7:4];
  assign kind    = s1_status_r[7:4];
  assign chan    = s1_status_r[3:0];
  assign is_note = (kind == KIND_NOTE_ON) || (kind == KIND_NOTE_OFF);

  // Look up the controller mask; numbers above 127 have no bit
  always_comb begin
    if (s1_data_one_r[7]) begin
      cc_masked = 1'b0;
    end else if (s1_data_one_r[6]) begin
      cc_masked = ui_cc_mask_high_r[s1_data_one_r[5:0]];
    end else begin
      cc_masked = ui_cc_mask_low_r[s1_data_one_r[5:0]];
    end
  end

  // Apply the rule chain
  assign drop_cin   = (cin < CIN_MIN) || (cin > CIN_MAX);
  assign drop_cable = (cable_zero_only_r && (cable != CABLE_ZERO))
                   || (drop_cable_fifteen_r && (cable == CABLE_FIFTEEN));
  assign drop_ui    = drop_ui_controls_r && (cable == CABLE_ZERO)
                   && ((is_note && (s1_data_one_r < UI_NOTE_LIMIT))
                       || ((kind == KIND_CC) && cc_masked));
  assign drop_notes = notes_only_r && !is_note;

  always_comb begin
    case (channel_mode_r)
      CHM_NONE:      drop_chan = 1'b0;
      CHM_CH3_ONLY:  drop_chan = !s1_status_r[7] || (chan != CHAN_THREE);
      CHM_BLOCK_CH1: drop_chan = s1_status_r[7] && (kind != KIND_SYSTEM)
                              && (chan == CHAN_ONE);
      CHM_CH5_TO_8:  drop_chan = !s1_status_r[7]
                              || ((kind != KIND_SYSTEM)
                                  && ((chan < CHAN_FIVE) || (chan > CHAN_EIGHT)));
      default:       drop_chan = 1'b0;
    endcase
  end

  assign ok = !(drop_cin || drop_cable || drop_ui || drop_notes || drop_chan);

  // Buffer tracking
  assign commit_nxt      = s1_last_r && (any_passed_r || ok);
  assign any_passed_nxt  = s1_last_r ? 1'b0 : (any_passed_r || ok);
  assign ready_count_nxt = ready_count_r + {7'd0, commit_nxt};

  // Hold the result until taken; load a new verdict on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      any_passed_r  <= 1'b0;
      ready_count_r <= '0;
    end else begin
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s2_load) begin
        any_passed_r  <= any_passed_nxt;
        ready_count_r <= ready_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_passed_r   <= ok;
      out_header_r   <= ok ? s1_header_r   : 8'd0;
      out_status_r   <= ok ? s1_status_r   : 8'd0;
      out_data_one_r <= ok ? s1_data_one_r : 8'd0;
      out_data_two_r <= ok ? s1_data_two_r : 8'd0;
      out_eob_r      <= s1_last_r;
      out_commit_r   <= commit_nxt;
    end
  end

  // Drive the result channel
  assign out_valid         = out_valid_r;
  assign out_passed        = out_passed_r;
  assign out_header        = out_header_r;
  assign out_status        = out_status_r;
  assign out_data_one      = out_data_one_r;
  assign out_data_two      = out_data_two_r;
  assign out_end_of_buffer = out_eob_r;
  assign out_commit        = out_commit_r;
  assign out_ready_count   = ready_count_r;

  // Checks
  a_commit_at_eob: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_commit_r |-> out_eob_r)
    else $error("commit reported away from end of buffer");

  a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_passed_r |-> (out_header_r == 8'd0) && (out_status_r == 8'd0)
      && (out_data_one_r == 8'd0) && (out_data_two_r == 8'd0))
    else $error("dropped packet carries non-zero bytes");

  a_count_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(ready_count_r) |-> out_valid_r && out_commit_r
      && (ready_count_r == $past(ready_count_r) + 8'd1))
    else $error("ready count moved without a commit");

  a_clear_at_eob: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load && s1_last_r |=> !any_passed_r)
    else $error("any-passed flag survived end of buffer");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free stage");

endmodule : usb_midi_packet_filter

// File: tb/usb_midi_packet_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_midi_packet_filter_test: self-checking bench for the USB-MIDI filter
// Streams packets through the filter under a series of rule settings and
// predicts each verdict, zeroed payload, buffer commit and committed-buffer
// count. Short directed runs cover the edge cases; random runs follow.
// Both handshakes see random stall and gap bursts.
// ----------------------------------------------------------------------------
module usb_midi_packet_filter_test;
  import umpf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 10;
  // Index past the register list; writes to it must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] status;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic       last_in_buffer;
  } packet_t;

  typedef struct packed {
    logic       passed;
    logic [7:0] header;
    logic [7:0] status;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic       end_of_buffer;
    logic       commit;
    logic [7:0] ready_count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_header = '0;
  logic [7:0]             in_status = '0;
  logic [7:0]             in_data_one = '0;
  logic [7:0]             in_data_two = '0;
  logic                   in_last_in_buffer = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_passed;
  logic [7:0]             out_header;
  logic [7:0]             out_status;
  logic [7:0]             out_data_one;
  logic [7:0]             out_data_two;
  logic                   out_end_of_buffer;
  logic                   out_commit;
  logic [7:0]             out_ready_count;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Filter settings as the bench believes them to be
  channel_mode_t flt_mode = CHM_NONE;
  logic          flt_notes_only = 1'b0;
  logic          flt_cable_zero_only = 1'b0;
  logic          flt_drop_cable15 = 1'b0;
  logic          flt_drop_ui = 1'b0;
  logic [127:0]  flt_cc_mask = '0;

  // Buffer tracking state
  logic       buf_any_passed = 1'b0;
  logic [7:0] buffers_committed = '0;

  packet_t     packets_to_send[$];
  verdict_t    expected_verdicts[$];
  packet_t     packet_on_bus;
  int unsigned idle_rate = 2;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  usb_midi_packet_filter uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_header         (in_header),
    .in_status         (in_status),
    .in_data_one       (in_data_one),
    .in_data_two       (in_data_two),
    .in_last_in_buffer (in_last_in_buffer),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_passed        (out_passed),
    .out_header        (out_header),
    .out_status        (out_status),
    .out_data_one      (out_data_one),
    .out_data_two      (out_data_two),
    .out_end_of_buffer (out_end_of_buffer),
    .out_commit        (out_commit),
    .out_ready_count   (out_ready_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Apply the rule chain in order; any rule that fires drops the packet
  function automatic logic packet_survives(packet_t p);
    logic [3:0] cin;
    logic [3:0] cable;
    logic [3:0] kind;
    logic [3:0] chan;
    logic       is_note;
    cin     = p.header[3:0];
    cable   = p.header[7:4];
    kind    = p.status[7:4];
    chan    = p.status[3:0];
    is_note = (kind == KIND_NOTE_ON) || (kind == KIND_NOTE_OFF);
    if (cin < CIN_MIN || cin > CIN_MAX) return 1'b0;
    if (flt_cable_zero_only && cable != CABLE_ZERO) return 1'b0;
    if (flt_drop_cable15 && cable == CABLE_FIFTEEN) return 1'b0;
    if (cable == CABLE_ZERO && flt_drop_ui) begin
      if (is_note && p.data_one < UI_NOTE_LIMIT) return 1'b0;
      // controllers above 127 have no mask bit
      if (kind == KIND_CC && !p.data_one[7] && flt_cc_mask[p.data_one[6:0]]) return 1'b0;
    end
    if (flt_notes_only && !is_note) return 1'b0;
    case (flt_mode)
      CHM_CH3_ONLY: begin
        if (!p.status[7] || chan != CHAN_THREE) return 1'b0;
      end
      CHM_BLOCK_CH1: begin
        if (p.status[7] && kind != KIND_SYSTEM && chan == CHAN_ONE) return 1'b0;
      end
      CHM_CH5_TO_8: begin
        if (!p.status[7]) return 1'b0;
        if (kind != KIND_SYSTEM && (chan < CHAN_FIVE || chan > CHAN_EIGHT)) return 1'b0;
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // Work out the result of one packet and advance the buffer state
  function automatic verdict_t predict_verdict(packet_t p);
    verdict_t v;
    logic     ok;
    ok = packet_survives(p);
    v  = '0;
    if (ok) buf_any_passed = 1'b1;
    if (p.last_in_buffer) begin
      v.commit = buf_any_passed;
      if (buf_any_passed) buffers_committed = buffers_committed + 8'd1;
      buf_any_passed = 1'b0;
    end
    v.passed        = ok;
    v.header        = ok ? p.header : 8'h00;
    v.status        = ok ? p.status : 8'h00;
    v.data_one      = ok ? p.data_one : 8'h00;
    v.data_two      = ok ? p.data_two : 8'h00;
    v.end_of_buffer = p.last_in_buffer;
    v.ready_count   = buffers_committed;
    return v;
  endfunction

  // Mostly well-formed traffic: valid code index, cable zero heavy, note/CC mix
  function automatic packet_t random_packet();
    packet_t     p;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) p.header[7:4] = CABLE_ZERO;
    else if (pick == 4) p.header[7:4] = CABLE_FIFTEEN;
    else p.header[7:4] = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) p.header[3:0] = 4'($urandom_range(0, 15));
    else p.header[3:0] = 4'($urandom_range(CIN_MIN, CIN_MAX));
    pick = $urandom_range(0, 9);
    if (pick < 3) p.status = {($urandom_range(0, 1) ? KIND_NOTE_ON : KIND_NOTE_OFF),
                              4'($urandom_range(0, 15))};
    else if (pick < 5) p.status = {KIND_CC, 4'($urandom_range(0, 15))};
    else if (pick == 5) p.status = {KIND_SYSTEM, 4'($urandom_range(0, 15))};
    else if (pick == 6) p.status = 8'($urandom_range(0, 127));
    else p.status = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 3) p.data_one = 8'($urandom_range(0, 12));
    else p.data_one = 8'($urandom_range(0, 255));
    p.data_two       = 8'($urandom_range(0, 255));
    p.last_in_buffer = ($urandom_range(0, 3) == 0);
    return p;
  endfunction

  task automatic queue_packet(input logic [7:0] hdr, input logic [7:0] st,
                              input logic [7:0] d1, input logic [7:0] d2,
                              input logic last);
    packets_to_send.push_back('{hdr, st, d1, d2, last});
  endtask

  // One register write, then track the setting
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CHANNEL_MODE:       flt_mode = channel_mode_t'(value[1:0]);
      REG_NOTES_ONLY:         flt_notes_only = value[0];
      REG_CABLE_ZERO_ONLY:    flt_cable_zero_only = value[0];
      REG_DROP_CABLE_FIFTEEN: flt_drop_cable15 = value[0];
      REG_DROP_UI_CONTROLS:   flt_drop_ui = value[0];
      REG_UI_CC_MASK_LOW:     flt_cc_mask[63:0] = value;
      REG_UI_CC_MASK_HIGH:    flt_cc_mask[127:64] = value;
      default: ;
    endcase
  endtask

  task automatic apply_config(input channel_mode_t mode, input logic notes,
                              input logic cable0, input logic cable15,
                              input logic ui, input logic [63:0] mask_lo,
                              input logic [63:0] mask_hi);
    write_reg(REG_CHANNEL_MODE, {62'd0, mode});
    write_reg(REG_NOTES_ONLY, {63'd0, notes});
    write_reg(REG_CABLE_ZERO_ONLY, {63'd0, cable0});
    write_reg(REG_DROP_CABLE_FIFTEEN, {63'd0, cable15});
    write_reg(REG_DROP_UI_CONTROLS, {63'd0, ui});
    write_reg(REG_UI_CC_MASK_LOW, mask_lo);
    write_reg(REG_UI_CC_MASK_HIGH, mask_hi);
  endtask

  // Hold until every queued packet has gone through and been checked
  task automatic wait_until_idle();
    do begin
      @(negedge clk);
    end while (packets_to_send.size() != 0 || in_valid || expected_verdicts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [63:0] random_mask();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sender: predict on each transfer, hold a stalled packet, insert gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) expected_verdicts.push_back(predict_verdict(packet_on_bus));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (packets_to_send.size() > 0 && $urandom_range(0, 9) < idle_rate) begin
          gap_left = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else if (packets_to_send.size() > 0) begin
          packet_on_bus = packets_to_send.pop_front();
          in_valid          <= 1'b1;
          in_header         <= packet_on_bus.header;
          in_status         <= packet_on_bus.status;
          in_data_one       <= packet_on_bus.data_one;
          in_data_two       <= packet_on_bus.data_two;
          in_last_in_buffer <= packet_on_bus.last_in_buffer;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transfer and stall in bursts
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_passed, out_header, out_status, out_data_one, out_data_two,
                out_end_of_buffer, out_commit, out_ready_count};
        if (expected_verdicts.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: passed=%0b hdr=%02h st=%02h count=%02h",
                     got.passed, got.header, got.status, got.ready_count);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.passed !== want.passed || got.header !== want.header ||
              got.status !== want.status || got.data_one !== want.data_one ||
              got.data_two !== want.data_two || got.end_of_buffer !== want.end_of_buffer ||
              got.commit !== want.commit || got.ready_count !== want.ready_count) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("mismatch: exp pass=%0b %02h %02h %02h %02h eob=%0b cm=%0b cnt=%02h",
                       want.passed, want.header, want.status, want.data_one, want.data_two,
                       want.end_of_buffer, want.commit, want.ready_count,
                       "\n          got pass=%0b %02h %02h %02h %02h eob=%0b cm=%0b cnt=%02h",
                       got.passed, got.header, got.status, got.data_one, got.data_two,
                       got.end_of_buffer, got.commit, got.ready_count);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) < idle_rate) begin
        stall_left = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    channel_mode_t mode;
    packet_t       p;
    int unsigned   n_items;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Code index bounds, byte extremes, a buffer with nothing passed
    apply_config(CHM_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
    queue_packet(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_packet(8'h07, 8'h90, 8'h40, 8'h7F, 1'b0);
    queue_packet(8'h0F, 8'h90, 8'h40, 8'h7F, 1'b0);
    queue_packet(8'h08, 8'h80, 8'h00, 8'h00, 1'b0);
    queue_packet(8'hFE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_until_idle();

    // Channel three only: status without its top bit is dropped
    write_reg(REG_CHANNEL_MODE, {62'd0, CHM_CH3_ONLY});
    queue_packet(8'h09, 8'h22, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'h09, 8'h92, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'h09, 8'h93, 8'h3C, 8'h40, 1'b1);
    wait_until_idle();

    // Block channel one: system and data bytes are never blocked
    write_reg(REG_CHANNEL_MODE, {62'd0, CHM_BLOCK_CH1});
    queue_packet(8'h0C, 8'hF0, 8'h11, 8'h22, 1'b0);
    queue_packet(8'h0C, 8'h05, 8'h11, 8'h22, 1'b0);
    queue_packet(8'h09, 8'h90, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'h09, 8'h91, 8'h3C, 8'h40, 1'b1);
    wait_until_idle();

    // Channels five to eight, system messages let through
    write_reg(REG_CHANNEL_MODE, {62'd0, CHM_CH5_TO_8});
    queue_packet(8'h09, 8'h15, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'h0E, 8'hF3, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'h09, 8'h94, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'h09, 8'h97, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'h09, 8'h93, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'h09, 8'h98, 8'h3C, 8'h40, 1'b1);
    wait_until_idle();

    // UI drop with every controller masked; controller above 127 survives
    apply_config(CHM_NONE, 1'b0, 1'b0, 1'b0, 1'b1, '1, '1);
    queue_packet(8'h09, 8'h90, 8'h09, 8'h40, 1'b0);
    queue_packet(8'h09, 8'h90, 8'h0A, 8'h40, 1'b0);
    queue_packet(8'h0B, 8'hB0, 8'h00, 8'h40, 1'b0);
    queue_packet(8'h0B, 8'hB0, 8'h7F, 8'h40, 1'b0);
    queue_packet(8'h0B, 8'hB0, 8'h80, 8'h40, 1'b0);
    queue_packet(8'h1B, 8'hB0, 8'h00, 8'h40, 1'b1);
    wait_until_idle();

    // Cable rules and notes only; a write past the register list is ignored
    apply_config(CHM_NONE, 1'b1, 1'b1, 1'b1, 1'b0, '0, '0);
    write_reg(REG_SPARE, '1);
    queue_packet(8'h19, 8'h90, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'hF9, 8'h90, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'h0B, 8'hB0, 8'h3C, 8'h40, 1'b0);
    queue_packet(8'h08, 8'h80, 8'h3C, 8'h40, 1'b1);
    wait_until_idle();

    // Random phases, each under its own setting
    for (int k = 0; k < 10; k++) begin
      if (k == 0) begin
        apply_config(CHM_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
      end else if (k == 1) begin
        apply_config(CHM_CH5_TO_8, 1'b1, 1'b1, 1'b1, 1'b1, '1, '1);
      end else if (k == 2) begin
        apply_config(CHM_NONE, 1'b0, 1'b0, 1'b0, 1'b1, {$urandom, $urandom},
                     {$urandom, $urandom});
      end else begin
        mode = channel_mode_t'(2'($urandom_range(0, 3)));
        apply_config(mode, ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), random_mask(),
                     random_mask());
      end
      // Some phases run without any idling; the last one always does
      idle_rate = (k % 3 == 2 || k == 9) ? 0 : $urandom_range(1, 4);
      // First phase closes a buffer on every packet to wrap the count
      n_items = (k == 0) ? 320 : 85;
      for (int i = 0; i < n_items; i++) begin
        p = random_packet();
        if (k == 0) p.last_in_buffer = 1'b1;
        packets_to_send.push_back(p);
      end
      wait_until_idle();
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
